// ===== rtl/tctb_pkg.sv =====
`default_nettype none
package tctb_pkg;

  localparam int TasksDefault = 8;
  localparam logic [15:0] TpsReset = 16'd1000;
  localparam int CondBits = 8;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_ARM_CNT  = 3'd1,
    OP_ARM_COND = 3'd2,
    OP_CANCEL   = 3'd3,
    OP_SET_WALL = 3'd4
  } op_e;

  typedef struct packed {
    logic        armed;
    logic        cnt_mode;
    logic [15:0] remaining;
  } slot_t;

  typedef struct packed {
    logic tick;
    logic set_wall;
  } time_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/task_countdown_timer_bank_top.sv =====
// Tick: every slot is walked in turn, then the result is strobed as busy drops; a new tick is taken once busy is low.
// Each slot is read from the slot memory in ST_RD and written back in ST_WR.
// Arm and cancel: one read-modify-write through ST_RD and ST_WR, busy until it is done.
// Set wall clock and unused codes: done at the accepting edge, busy stays low.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset clears all slots (per-entry valid bits), counters to zero, ticks per second to 1000.
`default_nettype none
module task_countdown_timer_bank_top #(
  parameter int TASKS = tctb_pkg::TasksDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  op_i,
  input  wire logic [2:0]  task_req_i,
  input  wire logic [15:0] delay_i,
  input  wire logic [7:0]  cond_clear_i,
  input  wire logic [31:0] clock_value_i,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  output logic             result_valid_o,
  output logic [7:0]       fired_mask_o,
  output logic [15:0]      uptime_ms_o,
  output logic [31:0]      uptime_s_o,
  output logic [31:0]      wall_clock_o
);
  import tctb_pkg::*;

  localparam int SlotW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TASKS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_WR
  } state_e;

  state_e           state_q, state_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [2:0]       op_q;
  logic [15:0]      delay_q;
  logic [7:0]       cond_q;
  logic [7:0]       fired_q, fired_d;
  logic             rv_q, rv_d;
  logic             accept;
  logic             slot_ok;
  logic             low_slot;
  logic [7:0]       cond_sh;
  time_ctl_t        tctl;
  slot_t            rdata, wdata;
  logic             hit;

  assign accept   = start_i && !busy_o;
  assign slot_ok  = 32'(task_req_i) < 32'(TASKS);
  assign low_slot = 32'(idx_q) < 32'(CondBits);
  assign cond_sh  = cond_q >> idx_q;

  assign tctl.tick     = accept && (op_i == OP_TICK);
  assign tctl.set_wall = accept && (op_i == OP_SET_WALL);

  always_comb begin
    wdata = rdata;
    hit   = 1'b0;
    unique case (op_q)
      OP_TICK: begin
        if (rdata.armed) begin
          if (rdata.cnt_mode) begin
            if (rdata.remaining == 16'd0) begin
              hit = 1'b1;
            end else begin
              wdata.remaining = rdata.remaining - 16'd1;
            end
          end else if (low_slot && cond_sh[0]) begin
            hit = 1'b1;
          end
        end
        if (hit) begin
          wdata.armed = 1'b0;
        end
      end
      OP_ARM_CNT: begin
        wdata.armed     = 1'b1;
        wdata.cnt_mode  = 1'b1;
        wdata.remaining = delay_q;
      end
      OP_ARM_COND: begin
        wdata.armed    = 1'b1;
        wdata.cnt_mode = 1'b0;
      end
      OP_CANCEL: begin
        wdata.armed = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    fired_d = fired_q;
    rv_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_TICK) begin
            state_d = ST_RD;
            idx_d   = '0;
            fired_d = '0;
          end else if ((op_i == OP_ARM_CNT || op_i == OP_ARM_COND ||
                        op_i == OP_CANCEL) && slot_ok) begin
            state_d = ST_RD;
            idx_d   = SlotW'(task_req_i);
          end
        end
      end
      ST_RD: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        if (op_q == OP_TICK) begin
          if (hit && low_slot) begin
            fired_d = fired_q | (8'd1 << idx_q);
          end
          if (idx_q == LastSlot) begin
            state_d = ST_IDLE;
            rv_d    = 1'b1;
          end else begin
            idx_d   = idx_q + SlotW'(1);
            state_d = ST_RD;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      fired_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fired_q <= fired_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      delay_q <= delay_i;
      cond_q  <= cond_clear_i;
    end
  end

  tctb_slot_mem #(
    .Tasks (TASKS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (state_q == ST_RD),
    .raddr_i (idx_q),
    .rdata_o (rdata),
    .we_i    (state_q == ST_WR),
    .waddr_i (idx_q),
    .wdata_i (wdata)
  );

  tctb_clock u_clock (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (tctl),
    .wall_val_i  (clock_value_i),
    .ms_o        (uptime_ms_o),
    .sec_o       (uptime_s_o),
    .wall_o      (wall_clock_o)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = rv_q;
  assign fired_mask_o   = fired_q;

endmodule
`default_nettype wire

// ===== rtl/tctb_slot_mem.sv =====
`default_nettype none
module tctb_slot_mem #(
  parameter int Tasks = tctb_pkg::TasksDefault,
  localparam int SlotW = (Tasks > 1) ? $clog2(Tasks) : 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               re_i,
  input  wire logic [SlotW-1:0]   raddr_i,
  output tctb_pkg::slot_t         rdata_o,
  input  wire logic               we_i,
  input  wire logic [SlotW-1:0]   waddr_i,
  input  wire tctb_pkg::slot_t    wdata_i
);
  import tctb_pkg::*;

  slot_t            mem_q [Tasks];
  logic [Tasks-1:0] valid_q;
  slot_t            rdata_q;

  // entries read as all zero until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/tctb_clock.sv =====
`default_nettype none
module tctb_clock (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [15:0]  cfg_wdata_i,
  input  wire tctb_pkg::time_ctl_t ctl_i,
  input  wire logic [31:0]  wall_val_i,
  output logic      [15:0]  ms_o,
  output logic      [31:0]  sec_o,
  output logic      [31:0]  wall_o
);
  import tctb_pkg::*;

  logic [15:0] tps_q;
  logic [15:0] ms_q, ms_d;
  logic [31:0] sec_q, sec_d;
  logic [31:0] wall_q, wall_d;
  logic [16:0] ms_next;

  always_comb begin
    ms_next = {1'b0, ms_q} + 17'd1;
    ms_d    = ms_q;
    sec_d   = sec_q;
    wall_d  = wall_q;
    if (ctl_i.tick) begin
      if (ms_next >= {1'b0, tps_q}) begin
        ms_d   = '0;
        sec_d  = sec_q + 32'd1;
        wall_d = wall_q + 32'd1;
      end else begin
        ms_d = ms_next[15:0];
      end
    end
    if (ctl_i.set_wall) begin
      wall_d = wall_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q  <= TpsReset;
      ms_q   <= '0;
      sec_q  <= '0;
      wall_q <= '0;
    end else begin
      if (cfg_we_i) begin
        tps_q <= cfg_wdata_i;
      end
      ms_q   <= ms_d;
      sec_q  <= sec_d;
      wall_q <= wall_d;
    end
  end

  assign ms_o   = ms_q;
  assign sec_o  = sec_q;
  assign wall_o = wall_q;

endmodule
`default_nettype wire
